@@ hdl/swap_slot_bitmap_allocator_assert.svh @@
// Assertion macros for the swap slot bitmap allocator checker.
// No dependencies; include by bare file name inside a module body.
`ifndef SWAP_SLOT_BITMAP_ALLOCATOR_ASSERT_SVH
`define SWAP_SLOT_BITMAP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SSBA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SSBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/ssba_pkg.sv @@
// Shared types, constants and codes for the swap slot bitmap allocator.
// No dependencies; imported by every module of the block except ssba_ram.
package ssba_pkg;

    localparam int SLOTS_DEFAULT = 4096;
    localparam int PAGE_BYTES    = 4096;
    localparam int PAGE_SHIFT    = $clog2(PAGE_BYTES);
    localparam int WORD_BITS     = 64;
    localparam int BIT_W         = $clog2(WORD_BITS);
    localparam int OFFSET_W      = 24;
    localparam int STATUS_W      = 2;
    localparam int COUNT_OUT_W   = 13;
    localparam int WIDE_W        = 48;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_MISALIGNED = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOT_USED   = 2'd3;

    typedef struct packed {
        logic                op;
        logic [OFFSET_W-1:0] free_offset;
    } ssba_req_t;

    typedef struct packed {
        logic [OFFSET_W-1:0]    slot_offset;
        logic [STATUS_W-1:0]    status;
        logic [COUNT_OUT_W-1:0] used_count;
    } ssba_rsp_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP
    } ssba_state_t;

    typedef struct packed {
        logic clear_step;
        logic take;
        logic commit;
    } ssba_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } ssba_status_t;

endpackage

@@ hdl/ssba_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ssba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/ssba_ctrl.sv @@
// Control state machine of the swap slot bitmap allocator.
// Depends on ssba_pkg.
module ssba_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  ssba_pkg::ssba_status_t st,
    output ssba_pkg::ssba_cmd_t    cmd
);
    import ssba_pkg::*;

    ssba_state_t state_reg;
    ssba_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (st.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                // hold until the response register can take the result
                if (st.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

@@ hdl/ssba_datapath.sv @@
// Datapath: bitmap RAM, word-full flags, slot count, request and response registers.
// Depends on ssba_pkg and ssba_ram.
module ssba_datapath #(
    parameter int SLOTS = ssba_pkg::SLOTS_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ssba_pkg::ssba_req_t    req,
    input  ssba_pkg::ssba_cmd_t    cmd,
    output ssba_pkg::ssba_status_t st,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output ssba_pkg::ssba_rsp_t    rsp
);
    import ssba_pkg::*;

    localparam int WORDS     = (SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int LAST_BITS = SLOTS - (WORDS - 1) * WORD_BITS;
    localparam logic [WORD_BITS-1:0] LAST_MASK =
        (LAST_BITS == WORD_BITS) ? {WORD_BITS{1'b1}}
                                 : ((WORD_BITS'(1) << LAST_BITS) - WORD_BITS'(1));
    localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(WORDS - 1);

    // summary and count
    logic [WORDS-1:0]   full_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [WORD_AW-1:0] clr_addr_reg;
    logic               out_valid_reg;
    ssba_rsp_t          rsp_reg;

    // held request
    logic                op_reg;
    logic [WORD_AW-1:0]  word_reg;
    logic [BIT_W-1:0]    bit_reg;
    logic                misal_reg;
    logic                oor_reg;
    logic [OFFSET_W-1:0] off_reg;

    // request decode
    logic [WIDE_W-1:0]    off_wide;
    logic [WORD_AW-1:0]   first_free_word;
    logic [WORD_AW-1:0]   req_word;
    logic                 req_misal;
    logic                 req_oor;

    // lookup
    logic [WORD_BITS-1:0] rdata;
    logic [WORD_BITS-1:0] vmask;
    logic [WORD_BITS-1:0] free_bits;
    logic [BIT_W-1:0]     first_free_bit;
    logic [WORD_BITS-1:0] set_word;
    logic [WORD_BITS-1:0] clr_word;
    logic                 alloc_ok;
    logic                 free_ok;
    logic [WIDE_W-1:0]    alloc_off_wide;
    logic [CNT_W-1:0]     count_next;
    logic [31:0]          count_wide;
    ssba_rsp_t            rsp_next;

    // RAM port signals
    logic                 ram_we;
    logic [WORD_AW-1:0]   ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;

    always_comb
    begin
        first_free_word = '0;
        for (int i = WORDS - 1; i >= 0; i--)
        begin
            if (!full_reg[i])
            begin
                first_free_word = WORD_AW'(i);
            end
        end
    end

    assign off_wide  = WIDE_W'(req.free_offset);
    assign req_misal = (off_wide[PAGE_SHIFT-1:0] != '0);
    assign req_oor   = ((off_wide >> PAGE_SHIFT) >= WIDE_W'(SLOTS));
    assign req_word  = (req.op == OP_FREE) ? off_wide[PAGE_SHIFT+BIT_W +: WORD_AW]
                                           : first_free_word;

    ssba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORDS),
        .AW    (WORD_AW)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.take),
        .raddr (req_word),
        .rdata (rdata)
    );

    assign vmask     = (word_reg == LAST_WORD) ? LAST_MASK : {WORD_BITS{1'b1}};
    assign free_bits = ~rdata & vmask;

    always_comb
    begin
        first_free_bit = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (free_bits[i])
            begin
                first_free_bit = BIT_W'(i);
            end
        end
    end

    assign set_word = rdata | (WORD_BITS'(1) << first_free_bit);
    assign clr_word = rdata & ~(WORD_BITS'(1) << bit_reg);
    assign alloc_ok = (count_reg != CNT_W'(SLOTS));
    assign free_ok  = !misal_reg && !oor_reg && rdata[bit_reg];
    assign alloc_off_wide = WIDE_W'({word_reg, first_free_bit}) << PAGE_SHIFT;

    always_comb
    begin
        count_next = count_reg;
        rsp_next   = '0;
        if (op_reg == OP_ALLOC)
        begin
            if (alloc_ok)
            begin
                count_next           = count_reg + CNT_W'(1);
                rsp_next.slot_offset = alloc_off_wide[OFFSET_W-1:0];
                rsp_next.status      = STATUS_OK;
            end
            else
            begin
                rsp_next.status = STATUS_FULL;
            end
        end
        else
        begin
            priority if (misal_reg)
            begin
                rsp_next.status = STATUS_MISALIGNED;
            end
            else if (!free_ok)
            begin
                rsp_next.status = STATUS_NOT_USED;
            end
            else
            begin
                if (count_reg != '0)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
                rsp_next.slot_offset = off_reg;
                rsp_next.status      = STATUS_OK;
            end
        end
        count_wide          = 32'(count_next);
        rsp_next.used_count = count_wide[COUNT_OUT_W-1:0];
    end

    // clearing sweep wins the write port; otherwise write back the changed word
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = word_reg;
        ram_wdata = '0;
        if (cmd.clear_step)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
        end
        else if (cmd.commit)
        begin
            ram_we    = (op_reg == OP_ALLOC) ? alloc_ok : free_ok;
            ram_wdata = (op_reg == OP_ALLOC) ? set_word : clr_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg      <= '0;
            count_reg     <= '0;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_addr_reg <= clr_addr_reg + WORD_AW'(1);
            end
            if (cmd.commit)
            begin
                count_reg <= count_next;
                if (op_reg == OP_ALLOC && alloc_ok)
                begin
                    full_reg[word_reg] <= ((set_word & vmask) == vmask);
                end
                else if (op_reg == OP_FREE && free_ok)
                begin
                    full_reg[word_reg] <= 1'b0;
                end
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            op_reg    <= req.op;
            word_reg  <= req_word;
            bit_reg   <= off_wide[PAGE_SHIFT +: BIT_W];
            misal_reg <= req_misal;
            oor_reg   <= req_oor;
            off_reg   <= req.free_offset;
        end
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign st.clear_last = (clr_addr_reg == LAST_WORD);
    assign st.out_free   = !out_valid_reg || rsp_ready;
    assign rsp_valid     = out_valid_reg;
    assign rsp           = rsp_reg;

endmodule

@@ hdl/swap_slot_bitmap_allocator.sv @@
// First-fit swap slot allocator: one use bit per slot kept in a bitmap RAM of 64-bit
// words, with a word-full flag per word in flip-flops to steer the search. An allocate
// request takes the lowest free slot and answers its byte offset (slot times the page
// size); a free request names a slot by byte offset and is refused, with nothing changed,
// if the offset is misaligned, lies past the last slot, or names a slot not in use.
// Each request beat gives exactly one response beat, carrying the slot count after the
// request. A request is handled in order: the bitmap word chosen by the flags (or by the
// offset) is read when the request is taken, then the bit is picked, the word written back
// and the response registered once the response register is free; the RAM's registered
// read port sets this order. Requests are taken one at a time, so a new request waits
// until the last one is committed, and a new request is taken while the previous response
// still waits. After reset the bitmap RAM is swept clear, one word a cycle, from the first
// word to the last, with req_ready held low.
// Depends on ssba_pkg, ssba_ctrl, ssba_datapath and ssba_ram.
module swap_slot_bitmap_allocator #(
    parameter int SLOTS = ssba_pkg::SLOTS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  ssba_pkg::ssba_req_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output ssba_pkg::ssba_rsp_t rsp
);
    import ssba_pkg::*;

    // command and status between the controller and the datapath
    ssba_cmd_t    cmd;
    ssba_status_t st;

    // sequence clearing, request take and commit
    ssba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .st        (st),
        .cmd       (cmd)
    );

    // hold the bitmap, flags and count; build the response beat
    ssba_datapath #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .st        (st),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

@@ hdl/ssba_checker.sv @@
// Port-level checks for the swap slot bitmap allocator, bound to the top level.
// Depends on ssba_pkg and swap_slot_bitmap_allocator_assert.svh.
module ssba_checker #(
    parameter int SLOTS = ssba_pkg::SLOTS_DEFAULT
) (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input ssba_pkg::ssba_rsp_t rsp
);
    import ssba_pkg::*;
    `include "swap_slot_bitmap_allocator_assert.svh"

    // stalled response beat holds
    `SSBA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "response changed while stalled")
    // one request at a time: no request is taken the cycle after one is
    `SSBA_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "request taken while one in flight")
    // refused requests carry a zero offset
    `SSBA_ASSERT_IMP(a_err_zero, rsp_valid && (rsp.status != STATUS_OK), rsp.slot_offset == '0, "error response with non-zero offset")
    // full is answered only when every slot is in use
    `SSBA_ASSERT_IMP(a_full_count, rsp_valid && (rsp.status == STATUS_FULL), rsp.used_count == COUNT_OUT_W'(SLOTS), "full status with slots left")

endmodule

bind swap_slot_bitmap_allocator ssba_checker #(.SLOTS(SLOTS)) u_checker (.*);
